// ----- hw/rtl/pscd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pscd_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int DIST_BITS = 50;

    typedef struct packed {
        logic signed [COORD_WIDTH_DEF-1:0] point_x;
        logic signed [COORD_WIDTH_DEF-1:0] point_y;
        logic signed [COORD_WIDTH_DEF-1:0] start_x;
        logic signed [COORD_WIDTH_DEF-1:0] start_y;
        logic signed [COORD_WIDTH_DEF-1:0] end_x;
        logic signed [COORD_WIDTH_DEF-1:0] end_y;
    } query_t;

    typedef enum logic [1:0] {
        REGION_A        = 2'd0,
        REGION_B        = 2'd1,
        REGION_INTERIOR = 2'd2
    } region_t;

    typedef struct packed {
        logic signed [COORD_WIDTH_DEF-1:0] closest_x;
        logic signed [COORD_WIDTH_DEF-1:0] closest_y;
        logic [DIST_BITS-1:0]              dist_sq;
        logic [1:0]                        region;
    } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/point_segment_closest_distance_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake        Payload
// query     start / busy     query  (query_t)
// result    done strobe      result (result_t), one cycle, cannot be held off
//
// One query is taken every cycle; busy is tied low. A query passes through the
// dot products, the one-bit-per-stage divider, then interpolation and distance.
// Reset clears the valid bits only.
module point_segment_closest_distance_top
    import pscd_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire query_t query,
    output logic      done,
    output result_t   result
);

    localparam int CW = COORD_WIDTH_DEF;
    localparam int SW = 2 * (CW + 1) + 1;

    logic f_v, d_v;
    logic signed [CW-1:0] f_px, f_py, f_ax, f_ay, f_bx, f_by;
    logic signed [CW-1:0] d_px, d_py, d_ax, d_ay, d_bx, d_by;
    logic signed [SW-1:0] f_dot;
    logic [SW-1:0] f_len;
    logic [1:0] d_region;
    logic [T_FRAC_BITS-1:0] d_t;

    assign busy = 1'b0;

    pscd_front #(.COORD_WIDTH(CW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .px(query.point_x), .py(query.point_y), .ax(query.start_x),
        .ay(query.start_y), .bx(query.end_x), .by(query.end_y),
        .out_valid(f_v), .o_px(f_px), .o_py(f_py), .o_ax(f_ax), .o_ay(f_ay),
        .o_bx(f_bx), .o_by(f_by), .o_dot(f_dot), .o_len(f_len)
    );

    pscd_divider #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .in_valid(f_v),
        .px(f_px), .py(f_py), .ax(f_ax), .ay(f_ay), .bx(f_bx), .by(f_by),
        .dot(f_dot), .len(f_len),
        .out_valid(d_v), .o_px(d_px), .o_py(d_py), .o_ax(d_ax), .o_ay(d_ay),
        .o_bx(d_bx), .o_by(d_by), .o_region(d_region), .o_t(d_t)
    );

    pscd_back #(.COORD_WIDTH(CW), .T_FRAC_BITS(T_FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(d_v),
        .px(d_px), .py(d_py), .ax(d_ax), .ay(d_ay), .bx(d_bx), .by(d_by),
        .region(d_region), .t(d_t),
        .out_valid(done), .closest_x(result.closest_x), .closest_y(result.closest_y),
        .dist_sq(result.dist_sq), .o_region(result.region)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/pscd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Differences, then the products of the two dot products (four multiplies side by side, summed at the output).
module pscd_front
    import pscd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int DW = COORD_WIDTH + 1,
    localparam int PW = 2 * DW,
    localparam int SW = PW + 1
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    output logic                               out_valid,
    output logic signed [COORD_WIDTH-1:0]      o_px,
    output logic signed [COORD_WIDTH-1:0]      o_py,
    output logic signed [COORD_WIDTH-1:0]      o_ax,
    output logic signed [COORD_WIDTH-1:0]      o_ay,
    output logic signed [COORD_WIDTH-1:0]      o_bx,
    output logic signed [COORD_WIDTH-1:0]      o_by,
    output logic signed [SW-1:0]               o_dot,
    output logic        [SW-1:0]               o_len
);

    logic v1_reg, v2_reg;
    logic signed [COORD_WIDTH-1:0] c1_reg [6];
    logic signed [COORD_WIDTH-1:0] c2_reg [6];
    logic signed [DW-1:0] abx_reg, aby_reg, apx_reg, apy_reg;
    logic signed [PW-1:0] m0_reg, m1_reg, m2_reg, m3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg[0] <= px; c1_reg[1] <= py; c1_reg[2] <= ax;
        c1_reg[3] <= ay; c1_reg[4] <= bx; c1_reg[5] <= by;
        abx_reg <= DW'(bx) - DW'(ax);
        aby_reg <= DW'(by) - DW'(ay);
        apx_reg <= DW'(px) - DW'(ax);
        apy_reg <= DW'(py) - DW'(ay);
        c2_reg  <= c1_reg;
        m0_reg  <= apx_reg * abx_reg;
        m1_reg  <= apy_reg * aby_reg;
        m2_reg  <= abx_reg * abx_reg;
        m3_reg  <= aby_reg * aby_reg;
    end

    assign out_valid = v2_reg;
    assign o_px = c2_reg[0];
    assign o_py = c2_reg[1];
    assign o_ax = c2_reg[2];
    assign o_ay = c2_reg[3];
    assign o_bx = c2_reg[4];
    assign o_by = c2_reg[5];
    assign o_dot = SW'(m0_reg) + SW'(m1_reg);
    assign o_len = SW'($unsigned(m2_reg)) + SW'($unsigned(m3_reg));

endmodule
`default_nettype wire

// ----- hw/rtl/pscd_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, fraction quotient.
module pscd_divider
    import pscd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int SW = 2 * (COORD_WIDTH + 1) + 1
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic signed [SW-1:0]          dot,
    input  wire logic        [SW-1:0]          len,
    output logic                               out_valid,
    output logic signed [COORD_WIDTH-1:0]      o_px,
    output logic signed [COORD_WIDTH-1:0]      o_py,
    output logic signed [COORD_WIDTH-1:0]      o_ax,
    output logic signed [COORD_WIDTH-1:0]      o_ay,
    output logic signed [COORD_WIDTH-1:0]      o_bx,
    output logic signed [COORD_WIDTH-1:0]      o_by,
    output logic [1:0]                         o_region,
    output logic [T_FRAC_BITS-1:0]             o_t
);

    localparam int N = T_FRAC_BITS + 1;

    logic                          v_reg   [N];
    logic signed [COORD_WIDTH-1:0] c_reg   [N][6];
    logic [1:0]                    reg_reg [N];
    logic [SW-1:0]                 r_reg   [N];
    logic [SW-1:0]                 l_reg   [N];
    logic [T_FRAC_BITS-1:0]        t_reg   [N];
    logic [1:0]                    reg0;

    always_comb
    begin
        if (dot[SW-1] || dot == '0)
            reg0 = REGION_A;
        else if ($unsigned(dot) >= len)
            reg0 = REGION_B;
        else
            reg0 = REGION_INTERIOR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < N; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg[0][0] <= px; c_reg[0][1] <= py; c_reg[0][2] <= ax;
        c_reg[0][3] <= ay; c_reg[0][4] <= bx; c_reg[0][5] <= by;
        reg_reg[0] <= reg0;
        r_reg[0]   <= $unsigned(dot);
        l_reg[0]   <= len;
        t_reg[0]   <= '0;
        for (int i = 1; i < N; i++)
        begin
            c_reg[i]   <= c_reg[i-1];
            reg_reg[i] <= reg_reg[i-1];
            l_reg[i]   <= l_reg[i-1];
            // for an interior query remainder < len < 2^(SW-1), so the shift never loses a bit
            if ({r_reg[i-1][SW-2:0], 1'b0} >= l_reg[i-1])
            begin
                r_reg[i] <= {r_reg[i-1][SW-2:0], 1'b0} - l_reg[i-1];
                t_reg[i] <= {t_reg[i-1][T_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg[i] <= {r_reg[i-1][SW-2:0], 1'b0};
                t_reg[i] <= {t_reg[i-1][T_FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign o_px = c_reg[N-1][0];
    assign o_py = c_reg[N-1][1];
    assign o_ax = c_reg[N-1][2];
    assign o_ay = c_reg[N-1][3];
    assign o_bx = c_reg[N-1][4];
    assign o_by = c_reg[N-1][5];
    assign o_region = reg_reg[N-1];
    assign o_t = t_reg[N-1];

endmodule
`default_nettype wire

// ----- hw/rtl/pscd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pick an endpoint or interpolate along the segment, then the squared distance, saturated to DIST_BITS.
module pscd_back
    import pscd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic [1:0]                    region,
    input  wire logic [T_FRAC_BITS-1:0]        t,
    output logic                               out_valid,
    output logic signed [COORD_WIDTH-1:0]      closest_x,
    output logic signed [COORD_WIDTH-1:0]      closest_y,
    output logic [DIST_BITS-1:0]               dist_sq,
    output logic [1:0]                         o_region
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int MW = DW + T_FRAC_BITS + 1;
    localparam int QW = 2 * DW;
    localparam int SQW = QW + 1;
    localparam logic signed [MW-1:0] HALF = MW'(1) <<< (T_FRAC_BITS - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [COORD_WIDTH-1:0] px1_reg, py1_reg, ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [COORD_WIDTH-1:0] px2_reg, py2_reg, cx2_reg, cy2_reg;
    logic signed [COORD_WIDTH-1:0] cx3_reg, cy3_reg, cx4_reg, cy4_reg;
    logic [1:0] r1_reg, r2_reg, r3_reg, r4_reg;
    logic signed [MW-1:0] mx1_reg, my1_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic [QW-1:0] sx4_reg, sy4_reg;
    logic signed [MW-1:0] rx, ry;
    logic signed [DW-1:0] cxw, cyw;
    logic [SQW-1:0] sum;
    logic signed [DW-1:0] dxn, dyn;

    assign rx  = (mx1_reg + HALF) >>> T_FRAC_BITS;
    assign ry  = (my1_reg + HALF) >>> T_FRAC_BITS;
    assign cxw = DW'(ax1_reg) + DW'(rx);
    assign cyw = DW'(ay1_reg) + DW'(ry);
    assign dxn = DW'(px2_reg) - DW'(cx2_reg);
    assign dyn = DW'(py2_reg) - DW'(cy2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px1_reg <= px; py1_reg <= py; ax1_reg <= ax; ay1_reg <= ay;
        bx1_reg <= bx; by1_reg <= by; r1_reg <= region;
        mx1_reg <= (DW'(bx) - DW'(ax)) * $signed({1'b0, t});
        my1_reg <= (DW'(by) - DW'(ay)) * $signed({1'b0, t});

        px2_reg <= px1_reg; py2_reg <= py1_reg; r2_reg <= r1_reg;
        unique case (r1_reg)
            REGION_B:
            begin
                cx2_reg <= bx1_reg; cy2_reg <= by1_reg;
            end
            REGION_INTERIOR:
            begin
                cx2_reg <= COORD_WIDTH'(cxw); cy2_reg <= COORD_WIDTH'(cyw);
            end
            default:
            begin
                cx2_reg <= ax1_reg; cy2_reg <= ay1_reg;
            end
        endcase

        cx3_reg <= cx2_reg; cy3_reg <= cy2_reg; r3_reg <= r2_reg;
        dx3_reg <= dxn; dy3_reg <= dyn;

        // widen before squaring so the full product is kept
        cx4_reg <= cx3_reg; cy4_reg <= cy3_reg; r4_reg <= r3_reg;
        sx4_reg <= $unsigned(QW'(dx3_reg) * QW'(dx3_reg));
        sy4_reg <= $unsigned(QW'(dy3_reg) * QW'(dy3_reg));
    end

    assign sum = SQW'(sx4_reg) + SQW'(sy4_reg);

    always_comb
    begin
        if (SQW > DIST_BITS && (sum >> DIST_BITS) != '0)
            dist_sq = '1;
        else
            dist_sq = DIST_BITS'(sum);
    end

    assign out_valid = v4_reg;
    assign closest_x = cx4_reg;
    assign closest_y = cy4_reg;
    assign o_region  = r4_reg;

endmodule
`default_nettype wire
